// ----- rtl/dtoi_pkg.sv -----
// dtoi_pkg: shared types and constants for the decimal text to int64 parser
// no dependencies; imported by the core, the top level, the checker and the testbench
`default_nettype none

package dtoi_pkg;

   localparam logic [7:0]  CHAR_ZERO  = 8'd48;
   localparam logic [7:0]  CHAR_NINE  = 8'd57;
   localparam logic [7:0]  CHAR_COMMA = 8'h2C;
   localparam logic [7:0]  CHAR_MINUS = 8'h2D;
   localparam logic [63:0] MAG_CAP    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] POS_MAX    = MAG_CAP - 64'd1;

   // one-hot parse phase
   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_MINUS  = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_COMMA  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic               parse_error;
      logic               overflow;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/dtoi_if.sv -----
// dtoi_req_if / dtoi_rsp_if: valid/ready channels of the parser
// no dependencies
`default_nettype none

interface dtoi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       start_flag;

   modport source (output valid, output char_code, output start_flag, input ready);
   modport sink   (input valid, input char_code, input start_flag, output ready);
endinterface

interface dtoi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;
   logic               parse_error;
   logic               overflow;

   modport source (output valid, output value, output parse_error, output overflow,
                   input ready);
   modport sink   (input valid, input value, input parse_error, input overflow,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/dtoi_core.sv -----
// dtoi_core: parse state registers and the per-character step logic
// depends on dtoi_pkg
`default_nettype none

module dtoi_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire logic [7:0]        char_code,
   input  wire logic              start_flag,
   output logic                   has_result,
   output dtoi_pkg::result_type   result
);
   import dtoi_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [63:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic        ovf_ff, ovf_in;

   logic        is_digit;
   logic [3:0]  char_diff;
   logic [63:0] base_mag;
   logic        base_ovf;
   logic [67:0] acc_sum;
   logic        acc_ovf;
   logic [63:0] acc_mag;
   logic [63:0] limit;
   logic        emit_ovf;
   result_type  err_res;
   result_type  val_res;

   assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign char_diff = 4'(char_code - CHAR_ZERO);

   // a start wipes the number in progress before this character counts
   assign base_mag = start_flag ? 64'd0 : mag_ff;
   assign base_ovf = start_flag ? 1'b0 : ovf_ff;

   // m*10 + d as shift-add; the sum exceeds the cap exactly when the
   // accumulate would leave the 2^63 range
   assign acc_sum = {1'b0, base_mag, 3'b000} + {3'b000, base_mag, 1'b0}
                  + {64'd0, char_diff};
   assign acc_ovf = base_ovf || (acc_sum > {4'd0, MAG_CAP});
   assign acc_mag = acc_ovf ? MAG_CAP : acc_sum[63:0];

   assign limit    = neg_ff ? MAG_CAP : POS_MAX;
   assign emit_ovf = ovf_ff || (mag_ff > limit);

   always_comb begin
      err_res.value       = 64'sd0;
      err_res.parse_error = 1'b1;
      err_res.overflow    = 1'b0;
      val_res.parse_error = 1'b0;
      val_res.overflow    = emit_ovf;
      if (emit_ovf) begin
         val_res.value = $signed(limit);
      end else if (neg_ff) begin
         val_res.value = $signed(64'd0 - mag_ff);
      end else begin
         val_res.value = $signed(mag_ff);
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      ovf_in     = ovf_ff;
      has_result = 1'b0;
      result     = val_res;
      if (start_flag) begin
         mag_in = 64'd0;
         neg_in = 1'b0;
         ovf_in = 1'b0;
         priority if (char_code == CHAR_MINUS) begin
            neg_in   = 1'b1;
            phase_in = PH_MINUS;
         end else if (is_digit) begin
            mag_in   = acc_mag;
            ovf_in   = acc_ovf;
            phase_in = PH_DIGITS;
         end else begin
            has_result = 1'b1;
            result     = err_res;
            phase_in   = PH_IDLE;
         end
      end else begin
         unique case (phase_ff)
            PH_MINUS: begin
               if (is_digit) begin
                  mag_in   = acc_mag;
                  ovf_in   = acc_ovf;
                  phase_in = PH_DIGITS;
               end else begin
                  has_result = 1'b1;
                  result     = err_res;
                  phase_in   = PH_IDLE;
               end
            end
            PH_DIGITS: begin
               priority if (is_digit) begin
                  mag_in = acc_mag;
                  ovf_in = acc_ovf;
               end else if (char_code == CHAR_COMMA) begin
                  phase_in = PH_COMMA;
               end else begin
                  has_result = 1'b1;
                  phase_in   = PH_IDLE;
               end
            end
            PH_COMMA: begin
               if (is_digit) begin
                  mag_in   = acc_mag;
                  ovf_in   = acc_ovf;
                  phase_in = PH_DIGITS;
               end else begin
                  has_result = 1'b1;
                  phase_in   = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         mag_ff   <= 64'd0;
         neg_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/decimal_text_to_int64.sv -----
// decimal_text_to_int64: streaming decimal text to signed 64-bit parser
// depends on dtoi_pkg, dtoi_req_if / dtoi_rsp_if and dtoi_core
//
// The block takes one character per cycle on req and emits at most one
// result per character on rsp. start_flag marks the first character of a
// number; a minus, then digits with single commas between digits, follow.
// The character that ends the run produces the result, which is registered
// in the result buffer; a missing first digit gives parse_error with value
// 0, and a magnitude past the signed 64-bit range saturates with overflow
// set. The sustained rate is one character per cycle, set by the accumulate
// loop (magnitude times ten plus digit, done as a shift-add and a compare
// against 2^63), which is combinational. A two-entry result buffer (output
// register plus skid) keeps characters flowing while a result waits; req
// only stalls when both entries hold results.
`default_nettype none

module decimal_text_to_int64 (
   input  wire logic   clock,
   input  wire logic   reset,
   dtoi_req_if.sink    req,
   dtoi_rsp_if.source  rsp
);
   import dtoi_pkg::*;

   logic       accept;
   logic       has_result;
   result_type step_res;
   logic       push;
   logic       pop;

   // result buffer: out is what rsp shows, skid catches one more
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   // free while the skid entry is empty
   assign req.ready = !skid_valid_ff;
   assign accept    = req.valid && req.ready;

   dtoi_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (accept),
      .char_code  (req.char_code),
      .start_flag (req.start_flag),
      .has_result (has_result),
      .result     (step_res)
   );

   assign push = accept && has_result;
   assign pop  = out_valid_ff && rsp.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // no new transaction can arrive here; drain skid into out
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = step_res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = step_res;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.value       = out_ff.value;
   assign rsp.parse_error = out_ff.parse_error;
   assign rsp.overflow    = out_ff.overflow;

endmodule

`default_nettype wire

// ----- rtl/dtoi_checker.sv -----
// dtoi_checker: port-level assertions for decimal_text_to_int64, with bind
// depends on dtoi_pkg and the top level's interface ports
`default_nettype none

module dtoi_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [63:0] rsp_value,
   input wire logic               rsp_parse_error,
   input wire logic               rsp_overflow
);
   import dtoi_pkg::*;

   // results are empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_parse_error && rsp_overflow))
      else $error("parse_error and overflow both set");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_parse_error) |-> (rsp_value == 64'sd0))
      else $error("error result with nonzero value");

   a_overflow_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |->
         ((rsp_value == $signed(MAG_CAP)) || (rsp_value == $signed(POS_MAX))))
      else $error("overflow result not saturated");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)))
      else $error("stalled result changed");

endmodule

bind decimal_text_to_int64 dtoi_checker u_dtoi_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_value       (rsp.value),
   .rsp_parse_error (rsp.parse_error),
   .rsp_overflow    (rsp.overflow)
);

`default_nettype wire

// ----- tb/sv/decimal_text_to_int64_tb.sv -----
// decimal_text_to_int64_tb: self-checking testbench for the decimal text to int64 parser
// depends on dtoi_pkg, dtoi_req_if / dtoi_rsp_if and the decimal_text_to_int64 top level
// a clocked driver and monitor, a cycle-free parse predictor and a result scoreboard
`timescale 1ns / 1ps

module decimal_text_to_int64_tb;
   import dtoi_pkg::*;

   // cycles without any transaction on either channel before the run is declared hung
   localparam int STALL_LIMIT = 2000;
   // cycles allowed after the last result for anything stray to come out
   localparam int TAIL_CYCLES = 10;

   // one character as it travels through the pending queue
   typedef struct packed {
      logic [7:0] code;
      logic       first;
   } char_item_type;

   logic clock = 1'b0;
   logic reset;

   dtoi_req_if req ();
   dtoi_rsp_if rsp ();

   decimal_text_to_int64 u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // pending characters and the results they are predicted to cause
   char_item_type char_queue[$];
   result_type expected_results[$];

   // idle percentages of the sender and the receiver, changed between phases
   int tx_idle_pct;
   int rx_idle_pct;

   // set by the monitor when the driven character was taken at the rising edge
   bit char_taken;

   int stall_cycles;
   int mismatches;
   int chars_queued;
   int chars_sent;
   int results_seen;
   int errors_seen;
   int overflows_seen;

   // parse state of the predictor
   phase_type   parse_phase;
   logic [63:0] parse_mag;
   logic        parse_neg;
   logic        parse_ovf;

   function automatic logic is_digit_code(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // magnitude times ten plus digit, saturating at 2^63 once the next step would pass it
   function automatic void add_digit(input logic [7:0] c);
      logic [63:0] d;
      d = {56'd0, c - CHAR_ZERO};
      if (parse_ovf || parse_mag > (MAG_CAP - d) / 64'd10) begin
         parse_ovf = 1'b1;
         parse_mag = MAG_CAP;
      end else begin
         parse_mag = parse_mag * 64'd10 + d;
      end
   endfunction

   // missing first digit: value zero with the error flag, then back to idle
   function automatic result_type digit_missing();
      result_type res;
      res = '0;
      res.parse_error = 1'b1;
      parse_phase = PH_IDLE;
      return res;
   endfunction

   // the run has ended: signed value, or the saturated extreme of its sign
   function automatic result_type finished_value();
      result_type  res;
      logic [63:0] limit;
      res = '0;
      limit = parse_neg ? MAG_CAP : POS_MAX;
      if (parse_ovf || parse_mag > limit) begin
         res.value = parse_neg ? MAG_CAP : POS_MAX;
         res.overflow = 1'b1;
      end else begin
         res.value = parse_neg ? (64'd0 - parse_mag) : parse_mag;
      end
      parse_phase = PH_IDLE;
      return res;
   endfunction

   // advance the predicted parse by one character; returns 1 when it causes a result
   function automatic logic parse_char(input char_item_type it, output result_type res);
      res = '0;
      if (it.first) begin
         // a start abandons whatever was in progress
         parse_mag = '0;
         parse_neg = 1'b0;
         parse_ovf = 1'b0;
         if (it.code == CHAR_MINUS) begin
            parse_neg = 1'b1;
            parse_phase = PH_MINUS;
            return 1'b0;
         end
         if (is_digit_code(it.code)) begin
            add_digit(it.code);
            parse_phase = PH_DIGITS;
            return 1'b0;
         end
         res = digit_missing();
         return 1'b1;
      end
      case (parse_phase)
         PH_MINUS: begin
            if (is_digit_code(it.code)) begin
               add_digit(it.code);
               parse_phase = PH_DIGITS;
               return 1'b0;
            end
            res = digit_missing();
            return 1'b1;
         end
         PH_DIGITS: begin
            if (is_digit_code(it.code)) begin
               add_digit(it.code);
               return 1'b0;
            end
            if (it.code == CHAR_COMMA) begin
               parse_phase = PH_COMMA;
               return 1'b0;
            end
            res = finished_value();
            return 1'b1;
         end
         PH_COMMA: begin
            // separator must be followed by a digit, anything else ends the number
            if (is_digit_code(it.code)) begin
               add_digit(it.code);
               parse_phase = PH_DIGITS;
               return 1'b0;
            end
            res = finished_value();
            return 1'b1;
         end
         default: begin
            // idle: characters without a start are dropped
            parse_phase = PH_IDLE;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input result_type want,
                                  input result_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch (%s): expected value=%0d err=%0b ovf=%0b, %s",
                  what, want.value, want.parse_error, want.overflow,
                  $sformatf("got value=%0d err=%0b ovf=%0b",
                            got.value, got.parse_error, got.overflow));
   endtask

   // monitor: scoreboard on rsp, prediction on req, hang watchdog
   always @(posedge clock) begin : monitor
      result_type want;
      result_type got;
      bit         moved;
      if (reset) begin
         parse_phase = PH_IDLE;
         parse_mag = '0;
         parse_neg = 1'b0;
         parse_ovf = 1'b0;
         stall_cycles = 0;
      end else begin
         moved = 1'b0;
         // result transaction: compare against the oldest prediction
         if (rsp.valid && rsp.ready) begin
            moved = 1'b1;
            results_seen++;
            got = {rsp.value, rsp.parse_error, rsp.overflow};
            if (got.parse_error)
               errors_seen++;
            if (got.overflow)
               overflows_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("no result expected", '0, got);
            end else begin
               want = expected_results.pop_front();
               if (got.value !== want.value || got.parse_error !== want.parse_error ||
                   got.overflow !== want.overflow)
                  report_mismatch("wrong field", want, got);
            end
         end
         // character transaction: predict what it causes
         if (req.valid && req.ready) begin
            moved = 1'b1;
            char_taken = 1'b1;
            chars_sent++;
            if (parse_char({req.char_code, req.start_flag}, want))
               expected_results.push_back(want);
         end
         if (moved)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // driver: new character and receiver ready change on the falling edge only
   always @(negedge clock) begin : driver
      char_item_type it;
      if (!reset) begin
         // hold the current character until it has been taken
         if (char_taken || !req.valid) begin
            char_taken = 1'b0;
            if (char_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               it = char_queue.pop_front();
               req.valid <= 1'b1;
               req.char_code <= it.code;
               req.start_flag <= it.first;
            end else begin
               req.valid <= 1'b0;
            end
         end
         rsp.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   task automatic push_item(input logic [7:0] c, input logic first);
      char_queue.push_back({c, first});
      chars_queued++;
   endtask

   // text whose first character carries the start flag
   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_item(s[i], i == 0);
   endtask

   function automatic logic [7:0] random_digit();
      return 8'(CHAR_ZERO + $urandom_range(0, 9));
   endfunction

   // any byte that is not a digit, optionally never a comma
   function automatic logic [7:0] random_stop(input bit allow_comma);
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (is_digit_code(c) || (!allow_comma && c == CHAR_COMMA))
         c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   // well-formed number with random length, sign, separators and ending
   task automatic push_random_number();
      int   ndig;
      int   sel;
      logic first;
      sel = $urandom_range(0, 99);
      ndig = (sel < 70) ? $urandom_range(1, 6) :
             (sel < 90) ? $urandom_range(7, 18) : $urandom_range(19, 22);
      first = 1'b1;
      if ($urandom_range(0, 2) == 0) begin
         push_item(CHAR_MINUS, 1'b1);
         first = 1'b0;
      end
      for (int i = 0; i < ndig; i++) begin
         push_item(random_digit(), first);
         first = 1'b0;
         if (i < ndig - 1 && $urandom_range(0, 5) == 0)
            push_item(CHAR_COMMA, 1'b0);
      end
      case ($urandom_range(0, 9))
         0: ; // left open: the next start abandons it
         1: begin
            push_item(CHAR_COMMA, 1'b0);
            push_item(random_stop(1'b1), 1'b0);
         end
         2: begin
            push_item(CHAR_COMMA, 1'b0);
            push_item(CHAR_COMMA, 1'b0);
         end
         default: push_item(random_stop(1'b0), 1'b0);
      endcase
   endtask

   // numbers right at the signed 64-bit limits, on either side
   task automatic push_boundary_number();
      string s;
      s = ($urandom_range(0, 1) == 1) ? "-922337203685477580" : "922337203685477580";
      push_text(s);
      if ($urandom_range(0, 1) == 1)
         push_item(8'(CHAR_ZERO + $urandom_range(5, 9)), 1'b0);
      else
         push_item(random_digit(), 1'b0);
      if ($urandom_range(0, 3) == 0)
         push_item(random_digit(), 1'b0);
      push_item(random_stop(1'b0), 1'b0);
   endtask

   // missing digits, a lone minus, restarts in the middle of a number
   task automatic push_broken_number();
      case ($urandom_range(0, 3))
         0: push_item(random_stop(1'b1), 1'b1);
         1: begin
            push_item(CHAR_MINUS, 1'b1);
            push_item(random_stop(1'b1), 1'b0);
         end
         2: push_item(CHAR_MINUS, 1'b1);
         default: begin
            push_item(random_digit(), 1'b1);
            push_item(CHAR_MINUS, 1'b1);
            push_item(random_stop(1'b1), 1'b0);
         end
      endcase
   endtask

   task automatic run_random(input int budget);
      int target;
      int sel;
      target = chars_queued + budget;
      while (chars_queued < target) begin
         sel = $urandom_range(0, 99);
         if (sel < 70)
            push_random_number();
         else if (sel < 78)
            push_boundary_number();
         else if (sel < 88)
            push_broken_number();
         else
            // noise without a start; mostly dropped by the idle parser
            repeat ($urandom_range(1, 3))
               char_queue.push_back({8'($urandom_range(0, 255)), 1'b0});
      end
   endtask

   // sender holds off until everything queued has gone out and every result is back
   task automatic wait_drained();
      while (char_queue.size() != 0 || req.valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.char_code = '0;
      req.start_flag = 1'b0;
      rsp.ready = 1'b0;
      char_taken = 1'b0;
      tx_idle_pct = 26;
      rx_idle_pct = 48;

      // directed characters: negative zero, missing digits, separators, restart
      push_text("-0");
      push_item(" ", 1'b0);
      push_item(8'h00, 1'b1);
      push_text("-");
      push_item("x", 1'b0);
      push_text("12,3");
      push_item(";", 1'b0);
      push_text("7,");
      push_item(CHAR_COMMA, 1'b0);
      push_text("5,");
      push_item("q", 1'b0);
      char_queue.push_back({8'hFF, 1'b0});
      push_item("4", 1'b1);
      push_text("9");
      push_item(" ", 1'b0);
      push_text("0");
      push_item(CHAR_MINUS, 1'b0);

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // receiver busier than the sender
      run_random(230);
      wait_drained();

      // sender busier than the receiver
      tx_idle_pct = 48;
      rx_idle_pct = 26;
      run_random(230);
      wait_drained();

      // back to back, no idling on either side
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_random(230);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0d predicted results never arrived", expected_results.size());
         mismatches += expected_results.size();
      end

      $display("sent %0d characters under three idle profiles, checked %0d results",
               chars_sent, results_seen);
      $display("of those %0d were parse errors and %0d saturated on overflow",
               errors_seen, overflows_seen);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL");
      end
      $finish;
   end

endmodule
